// ----- hdl/tli_pkg.sv -----
// Shared types, codes and constants of the table linear interpolator.
package tli_pkg;

  // Default configuration
  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths
  localparam int IN_BITS  = 32;
  localparam int OUT_BITS = 48;
  // Quotients at or above 2**SAT_BITS saturate outright
  localparam int SAT_BITS = 50;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STAT_ACCEPTED = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_INTERP   = 3'd2,
    STAT_EXTRAP   = 3'd3,
    STAT_BEFORE   = 3'd4,
    STAT_EMPTY    = 3'd5,
    STAT_SINGLE   = 3'd6,
    STAT_NONE     = 3'd7
  } status_t;

  // Main sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_CALC
  } state_t;

  // Multiply / divide unit phases
  typedef enum logic [1:0] {
    A_IDLE,
    A_MUL,
    A_DIV
  } ar_state_t;

endpackage

// ----- hdl/tli_store.sv -----
// Point store: time and radius memories, one write and one registered read port.
module tli_store #(
  parameter int DEPTH = tli_pkg::DEPTH_DEF,
  parameter int AW    = 10,
  parameter int SW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [SW-1:0] wtime,
  input  logic [SW-1:0] wradius,
  input  logic [AW-1:0] raddr,
  output logic [SW-1:0] rtime,
  output logic [SW-1:0] rradius
);

  logic [SW-1:0] time_mem_r [DEPTH];
  logic [SW-1:0] rad_mem_r  [DEPTH];
  logic [SW-1:0] rtime_r;
  logic [SW-1:0] rradius_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      time_mem_r[waddr] <= wtime;
      rad_mem_r[waddr]  <= wradius;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rtime_r   <= time_mem_r[raddr];
    rradius_r <= rad_mem_r[raddr];
  end

  assign rtime   = rtime_r;
  assign rradius = rradius_r;

endmodule

// ----- hdl/tli_muldiv.sv -----
// Shared arithmetic unit: one registered multiply, then restoring division a bit per cycle.
module tli_muldiv #(
  parameter int SW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SW-1:0]   a,
  input  logic [SW-1:0]   b,
  input  logic [SW-1:0]   d,
  output logic            done,
  output logic [2*SW-1:0] quo
);

  localparam int PW  = 2 * SW;
  localparam int CNW = $clog2(PW);

  tli_pkg::ar_state_t ph_r, ph_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic [SW-1:0]  a_r, b_r, d_r;
  logic [SW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  dvd_r, dvd_nxt;

  // Divide step: shift in the next dividend bit, subtract when it fits
  logic [SW:0] sh;
  logic [SW:0] diff;
  logic        ge;

  assign sh   = {rem_r, dvd_r[PW-1]};
  assign diff = sh - {1'b0, d_r};
  assign ge   = (sh >= {1'b0, d_r});

  always_comb begin
    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    unique case (ph_r)
      tli_pkg::A_IDLE: begin
        if (start) begin
          ph_nxt = tli_pkg::A_MUL;
        end
      end
      tli_pkg::A_MUL: begin
        // product forms the dividend; quotient bits enter at the bottom
        dvd_nxt = PW'(a_r) * PW'(b_r);
        rem_nxt = '0;
        cnt_nxt = CNW'(PW - 1);
        ph_nxt  = tli_pkg::A_DIV;
      end
      tli_pkg::A_DIV: begin
        rem_nxt = ge ? diff[SW-1:0] : sh[SW-1:0];
        dvd_nxt = {dvd_r[PW-2:0], ge};
        cnt_nxt = cnt_r - CNW'(1);
        if (cnt_r == '0) begin
          done_nxt = 1'b1;
          ph_nxt   = tli_pkg::A_IDLE;
        end
      end
      default: ph_nxt = tli_pkg::A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= tli_pkg::A_IDLE;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and datapath registers
  always_ff @(posedge clk) begin
    if (ph_r == tli_pkg::A_IDLE && start) begin
      a_r <= a;
      b_r <= b;
      d_r <= d;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign done = done_r;
  assign quo  = dvd_r;

endmodule

// ----- hdl/table_linear_interpolator.sv -----
// Top level: point table, scan sequencer and result register of the linear interpolator.
//
//   channel   ports                                       handshake
//   input     in_operation, in_sample_time,               start & !busy
//             in_sample_radius, in_query_time
//   result    out_radius_out, out_status                  out_valid, one cycle
//
// Append, clear and an undefined operation give their result in the cycle after
// acceptance; a query on an empty table does too. A query scans the stored points
// one per cycle through the memory read port, then runs the shared multiply and
// bit-serial divider on values of VALUE_BITS, counted at most 32, before its result.
// Reset empties the table at once by clearing the point count.
// The result strobe cannot be held off; busy stays high until a query's result.
module table_linear_interpolator #(
  parameter int TABLE_DEPTH = tli_pkg::DEPTH_DEF,
  parameter int VALUE_BITS  = tli_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_operation,
  input  logic [tli_pkg::IN_BITS-1:0]         in_sample_time,
  input  logic [tli_pkg::IN_BITS-1:0]         in_sample_radius,
  input  logic [tli_pkg::IN_BITS-1:0]         in_query_time,
  output logic                                out_valid,
  output logic signed [tli_pkg::OUT_BITS-1:0] out_radius_out,
  output logic [2:0]                          out_status
);

  localparam int SW = (VALUE_BITS < tli_pkg::IN_BITS) ? VALUE_BITS : tli_pkg::IN_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = 2 * SW;
  localparam int OB = tli_pkg::OUT_BITS;
  localparam int XB = tli_pkg::SAT_BITS + 2;

  tli_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic signed [OB-1:0] out_radius_r, out_radius_nxt;
  tli_pkg::status_t out_status_r, out_status_nxt;
  tli_pkg::status_t stat_r, stat_nxt;

  logic [SW-1:0] q_r, q_nxt;
  logic [SW-1:0] t0_r, t0_nxt;
  logic [SW-1:0] prev_t_r, prev_t_nxt, prev_r_r, prev_r_nxt;
  logic [SW-1:0] lt_r, lt_nxt, lr_r, lr_nxt, rt_r, rt_nxt, rr_r, rr_nxt;
  logic [SW-1:0] base_r, base_nxt;
  logic          neg_r, neg_nxt;

  // Memory ports
  logic          we;
  logic [AW-1:0] raddr;
  logic [SW-1:0] rd_t, rd_r;

  // Arithmetic unit ports
  logic          ar_start;
  logic [SW-1:0] ar_a, ar_b, ar_d;
  logic          ar_done;
  logic [PW-1:0] ar_quo;

  tli_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .SW    (SW)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (cnt_r[AW-1:0]),
    .wtime   (in_sample_time[SW-1:0]),
    .wradius (in_sample_radius[SW-1:0]),
    .raddr   (raddr),
    .rtime   (rd_t),
    .rradius (rd_r)
  );

  tli_muldiv #(
    .SW (SW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ar_start),
    .a     (ar_a),
    .b     (ar_b),
    .d     (ar_d),
    .done  (ar_done),
    .quo   (ar_quo)
  );

  // Scan compares
  logic last, hit;
  assign last = ((CW'(idx_r) + CW'(1)) == cnt_r);
  assign hit  = (idx_r != '0) && (q_r >= prev_t_r) && (q_r <= rd_t);

  // Operand preparation: signed differences and magnitudes
  logic [SW:0]   dr, den;
  logic [SW-1:0] dt;
  logic          interp;
  assign interp = (stat_r == tli_pkg::STAT_INTERP);
  assign dr     = {1'b0, rr_r} - {1'b0, lr_r};
  assign den    = {1'b0, rt_r} - {1'b0, lt_r};
  assign dt     = q_r - (interp ? lt_r : rt_r);
  assign ar_a   = dr[SW]  ? SW'(-dr)  : dr[SW-1:0];
  assign ar_b   = dt;
  assign ar_d   = den[SW] ? SW'(-den) : den[SW-1:0];

  // Final sum and saturation
  logic [63:0]          q64;
  logic                 q_sat;
  logic [XB-1:0]        mag, base_x;
  logic signed [XB-1:0] sum;
  logic                 sum_ok;
  logic signed [OB-1:0] res;

  assign q64    = 64'(ar_quo);
  assign q_sat  = |q64[63:tli_pkg::SAT_BITS];
  assign mag    = XB'(q64[tli_pkg::SAT_BITS-1:0]);
  assign base_x = XB'(base_r);
  assign sum    = neg_r ? $signed(base_x - mag) : $signed(base_x + mag);
  assign sum_ok = (sum[XB-1:OB-1] == '0) || (sum[XB-1:OB-1] == '1);

  always_comb begin
    if (q_sat) begin
      res = neg_r ? tli_pkg::OUT_MIN : tli_pkg::OUT_MAX;
    end else if (!sum_ok) begin
      res = sum[XB-1] ? tli_pkg::OUT_MIN : tli_pkg::OUT_MAX;
    end else begin
      res = sum[OB-1:0];
    end
  end

  // Sequencer: next state and outputs
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_radius_nxt = out_radius_r;
    out_status_nxt = out_status_r;
    stat_nxt       = stat_r;
    q_nxt          = q_r;
    t0_nxt         = t0_r;
    prev_t_nxt     = prev_t_r;
    prev_r_nxt     = prev_r_r;
    lt_nxt         = lt_r;
    lr_nxt         = lr_r;
    rt_nxt         = rt_r;
    rr_nxt         = rr_r;
    base_nxt       = base_r;
    neg_nxt        = neg_r;
    we             = 1'b0;
    raddr          = '0;
    ar_start       = 1'b0;
    unique case (state_r)
      tli_pkg::S_IDLE: begin
        if (start) begin
          out_radius_nxt = '0;
          case (in_operation)
            tli_pkg::OP_APPEND: begin
              out_valid_nxt = 1'b1;
              if (cnt_r < CW'(TABLE_DEPTH)) begin
                we             = 1'b1;
                cnt_nxt        = cnt_r + CW'(1);
                out_status_nxt = tli_pkg::STAT_ACCEPTED;
              end else begin
                out_status_nxt = tli_pkg::STAT_FULL;
              end
            end
            tli_pkg::OP_CLEAR: begin
              out_valid_nxt  = 1'b1;
              cnt_nxt        = '0;
              out_status_nxt = tli_pkg::STAT_ACCEPTED;
            end
            tli_pkg::OP_QUERY: begin
              q_nxt   = in_query_time[SW-1:0];
              idx_nxt = '0;
              if (cnt_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = tli_pkg::STAT_EMPTY;
              end else begin
                state_nxt = tli_pkg::S_SCAN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = tli_pkg::STAT_NONE;
            end
          endcase
        end
      end
      tli_pkg::S_SCAN: begin
        // entry idx_r is on the read data; fetch the one after it
        raddr      = idx_r + AW'(1);
        prev_t_nxt = rd_t;
        prev_r_nxt = rd_r;
        if (idx_r == '0) begin
          t0_nxt = rd_t;
        end
        if (hit) begin
          lt_nxt    = prev_t_r;
          lr_nxt    = prev_r_r;
          rt_nxt    = rd_t;
          rr_nxt    = rd_r;
          stat_nxt  = tli_pkg::STAT_INTERP;
          state_nxt = tli_pkg::S_PREP;
        end else if (last) begin
          if (idx_r == '0) begin
            // single point: its radius as is
            out_valid_nxt  = 1'b1;
            out_radius_nxt = OB'(rd_r);
            out_status_nxt = tli_pkg::STAT_SINGLE;
            state_nxt      = tli_pkg::S_IDLE;
          end else if (q_r > rd_t) begin
            lt_nxt    = prev_t_r;
            lr_nxt    = prev_r_r;
            rt_nxt    = rd_t;
            rr_nxt    = rd_r;
            stat_nxt  = tli_pkg::STAT_EXTRAP;
            state_nxt = tli_pkg::S_PREP;
          end else begin
            out_valid_nxt  = 1'b1;
            out_radius_nxt = '0;
            out_status_nxt = (q_r < t0_r) ? tli_pkg::STAT_BEFORE : tli_pkg::STAT_NONE;
            state_nxt      = tli_pkg::S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      tli_pkg::S_PREP: begin
        if (den == '0) begin
          // equal times: left radius, no division
          out_valid_nxt  = 1'b1;
          out_radius_nxt = OB'(lr_r);
          out_status_nxt = stat_r;
          state_nxt      = tli_pkg::S_IDLE;
        end else begin
          ar_start  = 1'b1;
          base_nxt  = interp ? lr_r : rr_r;
          neg_nxt   = dr[SW] ^ den[SW];
          state_nxt = tli_pkg::S_CALC;
        end
      end
      tli_pkg::S_CALC: begin
        if (ar_done) begin
          out_valid_nxt  = 1'b1;
          out_radius_nxt = res;
          out_status_nxt = stat_r;
          state_nxt      = tli_pkg::S_IDLE;
        end
      end
      default: state_nxt = tli_pkg::S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tli_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    out_radius_r <= out_radius_nxt;
    out_status_r <= out_status_nxt;
    stat_r       <= stat_nxt;
    q_r          <= q_nxt;
    t0_r         <= t0_nxt;
    prev_t_r     <= prev_t_nxt;
    prev_r_r     <= prev_r_nxt;
    lt_r         <= lt_nxt;
    lr_r         <= lr_nxt;
    rt_r         <= rt_nxt;
    rr_r         <= rr_nxt;
    base_r       <= base_nxt;
    neg_r        <= neg_nxt;
  end

  assign busy           = (state_r != tli_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_radius_out = out_radius_r;
  assign out_status     = out_status_r;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_DEPTH))
    else $error("point count beyond table depth");

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_operation == tli_pkg::OP_APPEND ||
                       in_operation == tli_pkg::OP_CLEAR) |=> out_valid)
    else $error("append or clear item gave no result");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while sequencer busy");

  a_done_calc: assert property (@(posedge clk) disable iff (!rst_n)
    ar_done |-> state_r == tli_pkg::S_CALC)
    else $error("divider finished outside calculation");

  a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == tli_pkg::S_SCAN |-> CW'(idx_r) < cnt_r)
    else $error("scan index beyond stored points");
`endif

endmodule

// ----- verif/table_linear_interpolator_tb.sv -----
// Self-checking testbench for the table linear interpolator: directed, full-table and random items.
module table_linear_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         TBL_DEPTH    = tli_pkg::DEPTH_DEF;
  localparam int         RANDOM_ITEMS = 500;
  localparam int         OUT_W        = tli_pkg::OUT_BITS;
  localparam int         IN_W         = tli_pkg::IN_BITS;
  localparam int         SAT_W        = tli_pkg::SAT_BITS;
  localparam logic [1:0] OP_UNDEF     = 2'd3;

  typedef struct {
    logic signed [OUT_W-1:0] radius;
    tli_pkg::status_t        status;
  } outcome_t;

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    start            = 1'b0;
  logic [1:0]              in_operation     = '0;
  logic [IN_W-1:0]         in_sample_time   = '0;
  logic [IN_W-1:0]         in_sample_radius = '0;
  logic [IN_W-1:0]         in_query_time    = '0;
  logic                    busy;
  logic                    out_valid;
  logic signed [OUT_W-1:0] out_radius_out;
  logic [2:0]              out_status;

  // Shadow copy of the point table
  bit [31:0] time_mem [TBL_DEPTH];
  bit [31:0] rad_mem  [TBL_DEPTH];
  int        point_cnt = 0;

  outcome_t pending_results[$];
  int       err_cnt     = 0;
  int       items_sent  = 0;
  int       results_seen = 0;
  bit       pace_on     = 1'b1;

  table_linear_interpolator uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_sample_time   (in_sample_time),
    .in_sample_radius (in_sample_radius),
    .in_query_time    (in_query_time),
    .out_valid        (out_valid),
    .out_radius_out   (out_radius_out),
    .out_status       (out_status)
  );

  always #2 clk = ~clk;

  // base + trunc(dr * dt / den), saturated to the signed output range
  function automatic logic signed [OUT_W-1:0] scaled_offset(bit [31:0] base, longint dr,
                                                            bit [63:0] dt, longint den);
    bit         neg;
    bit [127:0] prod;
    bit [127:0] quo;
    longint     sum;
    neg  = (dr < 0) != (den < 0);
    prod = 128'(dr < 0 ? -dr : dr) * 128'(dt);
    quo  = prod / 128'(den < 0 ? -den : den);
    if (quo >= (128'd1 << SAT_W)) return neg ? tli_pkg::OUT_MIN : tli_pkg::OUT_MAX;
    sum = longint'(base) + (neg ? -longint'(quo[63:0]) : longint'(quo[63:0]));
    if (sum > tli_pkg::OUT_MAX) return tli_pkg::OUT_MAX;
    if (sum < tli_pkg::OUT_MIN) return tli_pkg::OUT_MIN;
    return sum[OUT_W-1:0];
  endfunction

  // Applies one item to the shadow table and works out its result
  function automatic outcome_t compute_response(bit [1:0] op, bit [31:0] t_in, bit [31:0] r_in,
                                                bit [31:0] q);
    outcome_t  res;
    bit        found;
    bit [31:0] t1, t2, r1, r2;
    res.radius = '0;
    res.status = tli_pkg::STAT_NONE;
    case (op)
      tli_pkg::OP_APPEND: begin
        if (point_cnt < TBL_DEPTH) begin
          time_mem[point_cnt] = t_in;
          rad_mem[point_cnt]  = r_in;
          point_cnt++;
          res.status = tli_pkg::STAT_ACCEPTED;
        end else begin
          res.status = tli_pkg::STAT_FULL;
        end
      end
      tli_pkg::OP_CLEAR: begin
        point_cnt  = 0;
        res.status = tli_pkg::STAT_ACCEPTED;
      end
      tli_pkg::OP_QUERY: begin
        if (point_cnt == 0) begin
          res.status = tli_pkg::STAT_EMPTY;
        end else if (point_cnt == 1) begin
          res.radius = OUT_W'(rad_mem[0]);
          res.status = tli_pkg::STAT_SINGLE;
        end else begin
          found = 1'b0;
          // first bracketing pair wins, both ends inclusive
          for (int i = 0; i + 1 < point_cnt && !found; i++) begin
            t1 = time_mem[i];
            t2 = time_mem[i+1];
            if (q >= t1 && q <= t2) begin
              found      = 1'b1;
              res.status = tli_pkg::STAT_INTERP;
              if (t1 == t2)
                res.radius = OUT_W'(rad_mem[i]);
              else
                res.radius = scaled_offset(rad_mem[i],
                                           longint'(rad_mem[i+1]) - longint'(rad_mem[i]),
                                           64'(q - t1), longint'(t2 - t1));
            end
          end
          if (!found) begin
            t1 = time_mem[point_cnt-2];
            t2 = time_mem[point_cnt-1];
            r1 = rad_mem[point_cnt-2];
            r2 = rad_mem[point_cnt-1];
            if (q > t2) begin
              res.status = tli_pkg::STAT_EXTRAP;
              if (t1 == t2)
                res.radius = OUT_W'(r1);
              else
                res.radius = scaled_offset(r2, longint'(r2) - longint'(r1), 64'(q - t2),
                                           longint'(t2) - longint'(t1));
            end else if (q < time_mem[0]) begin
              res.status = tli_pkg::STAT_BEFORE;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Drives one item, waits for it to be taken, then idles for a random gap
  task automatic issue_item(bit [1:0] op, bit [31:0] t_in, bit [31:0] r_in, bit [31:0] q);
    int gap;
    in_operation     <= op;
    in_sample_time   <= t_in;
    in_sample_radius <= r_in;
    in_query_time    <= q;
    start            <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.insert(pending_results.size(), compute_response(op, t_in, r_in, q));
    if (op != OP_UNDEF) items_sent++;
    gap = pace_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Holds the sender off until every outstanding result is back
  task automatic await_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Hand-picked items: empty, single, bracketing, equal times, unsorted, saturation
  task automatic test_directed_cases();
    pace_on = 1'b1;
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), $urandom());
    issue_item(OP_UNDEF, $urandom(), $urandom(), $urandom());
    issue_item(tli_pkg::OP_APPEND, 32'd100, 32'd5000, $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'hFFFF_FFFF);
    issue_item(tli_pkg::OP_APPEND, 32'd200, 32'd3000, $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd150);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd100);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd200);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd300);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd50);
    issue_item(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd0);
    // two points at one time, inside and past the interval
    issue_item(tli_pkg::OP_APPEND, 32'd10, 32'd7, $urandom());
    issue_item(tli_pkg::OP_APPEND, 32'd10, 32'd9, $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd10);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd20);
    // falling times: negative slope with truncation toward zero
    issue_item(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
    issue_item(tli_pkg::OP_APPEND, 32'd500, 32'd100, $urandom());
    issue_item(tli_pkg::OP_APPEND, 32'd400, 32'd307, $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd603);
    // steep slope: quotient overflow, then range clamp, then negative overflow
    issue_item(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
    issue_item(tli_pkg::OP_APPEND, 32'd0, 32'd0, $urandom());
    issue_item(tli_pkg::OP_APPEND, 32'd1, 32'hFFFF_FFFF, $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'hFFFF_FFFF);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd65537);
    issue_item(tli_pkg::OP_APPEND, 32'd2, 32'd0, $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'hFFFF_FFFF);
  endtask

  // Fills the table to the brim, overfills it and queries across the whole depth
  task automatic test_table_full();
    bit [31:0] t_last;
    pace_on = 1'($urandom_range(0, 1));
    issue_item(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
    for (int i = 0; i < TBL_DEPTH; i++)
      issue_item(tli_pkg::OP_APPEND, 32'(i * 4096 + $urandom_range(1, 4095)), $urandom(),
                 $urandom());
    t_last = time_mem[TBL_DEPTH-1];
    issue_item(tli_pkg::OP_APPEND, $urandom(), $urandom(), $urandom());
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), t_last - 32'd1);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), t_last + 32'd12345);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'd0);
    issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), 32'(TBL_DEPTH * 2048));
    await_all_results();
    issue_item(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
  endtask

  // Random tables built then queried, with some noise items in between
  task automatic test_random_sequences();
    bit [31:0] pt_time[$];
    bit [32:0] acc;
    bit [31:0] step_max, rad_max, t_new, q;
    int        goal, n_pts, idx;
    bit        shuffled;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      pace_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        // noise: any operation with arbitrary fields
        repeat ($urandom_range(1, 4))
          issue_item(2'($urandom_range(tli_pkg::OP_APPEND, OP_UNDEF)), $urandom(), $urandom(),
                     $urandom());
      end else begin
        issue_item(tli_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom());
        pt_time.delete();
        if ($urandom_range(0, 9) == 0)
          n_pts = $urandom_range(0, 1);
        else if ($urandom_range(0, 19) == 0)
          n_pts = $urandom_range(13, 60);
        else
          n_pts = $urandom_range(2, 12);
        case ($urandom_range(0, 3))
          0:       step_max = 32'd2;
          1:       step_max = 32'd1000;
          2:       step_max = 32'd1 << 24;
          default: step_max = 32'd1 << 30;
        endcase
        rad_max  = $urandom_range(0, 1) ? 32'd1000 : 32'hFFFF_FFFF;
        shuffled = ($urandom_range(0, 4) == 0);
        acc      = ($urandom_range(0, 3) == 0) ? 33'($urandom()) : 33'($urandom_range(0, 1000));
        repeat (n_pts) begin
          if (shuffled) acc = 33'($urandom());
          t_new = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
          pt_time.insert(pt_time.size(), t_new);
          issue_item(tli_pkg::OP_APPEND, t_new, $urandom_range(0, rad_max), $urandom());
          acc = acc + $urandom_range(0, step_max);
        end
        repeat ($urandom_range(1, 6)) begin
          q = $urandom();
          if (pt_time.size() > 0) begin
            idx = $urandom_range(0, pt_time.size() - 1);
            case ($urandom_range(0, 4))
              0: q = pt_time[idx];
              1: if (idx + 1 < pt_time.size()) q = $urandom_range(pt_time[idx], pt_time[idx+1]);
              2: begin
                acc = 33'(pt_time[$]) + $urandom_range(1, step_max);
                q   = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
              end
              3: q = (pt_time[0] == 0) ? 32'd0 : $urandom_range(0, pt_time[0] - 1);
              default: ;
            endcase
          end
          issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), q);
        end
        // an undefined operation must leave the table alone
        if ($urandom_range(0, 4) == 0) begin
          issue_item(OP_UNDEF, $urandom(), $urandom(), $urandom());
          issue_item(tli_pkg::OP_QUERY, $urandom(), $urandom(), $urandom());
        end
      end
      if ($urandom_range(0, 15) == 0) await_all_results();
    end
  endtask

  // Result checker: every strobe must match the oldest outstanding expectation
  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result %0d with nothing outstanding: radius %0d status %0d",
                 $time, results_seen, out_radius_out, out_status);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (out_radius_out !== want.radius) begin
          $display("%0t: result %0d radius expected %0d actual %0d",
                   $time, results_seen, want.radius, out_radius_out);
          err_cnt++;
        end
        if (out_status !== want.status) begin
          $display("%0t: result %0d status expected %0d actual %0d",
                   $time, results_seen, want.status, out_status);
          err_cnt++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_table_full();
    test_random_sequences();
    await_all_results();
    repeat (8) @(posedge clk);
    if (err_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
